@@ rtl/bthalloc_pkg.sv @@
// bthalloc_pkg.sv: types, sizes and codes shared by the block table heap allocator
`timescale 1ns / 1ps
package bthalloc_pkg;

    // heap geometry
    localparam int NUM_BLOCKS      = 4096;
    localparam int BLOCK_SIZE_LOG2 = 12;

    // field and register widths
    localparam int ADDR_W     = 32;
    localparam int BIU_W      = 13;
    localparam int ENT_W      = 3;
    localparam int CFG_ADDR_W = 1;

    // derived widths
    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int LEN_W = ADDR_W + 1 - BLOCK_SIZE_LOG2;
    localparam int FIX_W = ADDR_W - BLOCK_SIZE_LOG2;
    localparam int USE_CMP_W = (CNT_W > BIU_W) ? CNT_W : BIU_W;
    localparam int LEN_CMP_W = (LEN_W > CNT_W) ? LEN_W : CNT_W;
    localparam int FIX_CMP_W = (FIX_W > CNT_W) ? FIX_W : CNT_W;

    // byte offset mask inside one block
    localparam logic [ADDR_W-1:0] BLK_MASK = ADDR_W'((64'd1 << BLOCK_SIZE_LOG2) - 64'd1);

    // table entry bits
    localparam logic [ENT_W-1:0] ENT_TAKEN = 3'b001;
    localparam logic [ENT_W-1:0] ENT_FIRST = 3'b010;
    localparam logic [ENT_W-1:0] ENT_NEXT  = 3'b100;
    localparam logic [ENT_W-1:0] ENT_FREE  = 3'b000;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_HEAP_BASE     = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;

    // configuration reset values
    localparam logic [ADDR_W-1:0] HEAP_BASE_RST     = '0;
    localparam logic [BIU_W-1:0]  BLOCKS_IN_USE_RST = 13'd4096;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADADDR = 2'd2
    } t_status;

    // request kinds
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // request and result payloads
    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] request_bytes;
        logic [ADDR_W-1:0] release_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        t_status           status;
    } t_resp;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_FREE_RD,
        S_FREE_WR,
        S_RESP
    } t_state;

endpackage

@@ rtl/block_table_heap_allocator.sv @@
// block_table_heap_allocator.sv: first-fit block table heap allocator, top level
//
//  channel   direction  handshake                  payload
//  request   in         i_in_valid / o_in_stall    i_in_data  (t_req)
//  result    out        o_out_valid / i_out_stall  o_out_data (t_resp)
//  config    in         i_cfg_we                   i_cfg_addr, i_cfg_wdata
//
// one request at a time; the block table ram (one read, one write port) sets the pace.
// allocate: the scan reads the table entry by entry, then the granted run is written.
// free: the head is read, then each block on the chain is cleared; early errors skip both.
// after reset a clearing pass over the whole table runs before the first request.
// a finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
module block_table_heap_allocator (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  bthalloc_pkg::t_req                       i_in_data,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output bthalloc_pkg::t_resp                      o_out_data,
    input  logic                                     i_cfg_we,
    input  logic [bthalloc_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [bthalloc_pkg::ADDR_W-1:0]          i_cfg_wdata
);

    import bthalloc_pkg::*;

    // control and config registers
    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_heap_base;
    logic [BIU_W-1:0]  r_biu;
    logic              r_out_valid, n_out_valid;
    t_resp             r_out_data, n_out_data;
    t_resp             r_res, n_res;
    logic [CNT_W-1:0]  r_len, n_len;
    logic [CNT_W-1:0]  r_run, n_run;
    logic [IDX_W-1:0]  r_first, n_first;
    logic [CNT_W-1:0]  r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]  r_chk_idx, n_chk_idx;
    logic              r_chk_vld, n_chk_vld;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_mk, n_mk;

    // ram ports
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    // helper values
    logic [CNT_W-1:0]  used;
    logic [ADDR_W-1:0] base_al;
    logic [ADDR_W:0]   bytes_sum;
    logic [LEN_W-1:0]  req_len;
    logic [ADDR_W-1:0] rel_diff;
    logic [FIX_W-1:0]  rel_idx;
    logic              out_free;
    logic              scan_issue;
    logic [IDX_W-1:0]  run_start;
    logic [CNT_W-1:0]  run_next;
    logic [CNT_W-1:0]  mk_next;
    logic [CNT_W-1:0]  mk_addr;
    logic [CNT_W-1:0]  free_next;

    bthalloc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // effective block count and aligned base
    assign used = (USE_CMP_W'(r_biu) > USE_CMP_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                                : CNT_W'(r_biu);
    assign base_al = r_heap_base & ~BLK_MASK;

    // request decode
    assign bytes_sum = {1'b0, i_in_data.request_bytes} + {1'b0, BLK_MASK};
    assign req_len   = bytes_sum[ADDR_W:BLOCK_SIZE_LOG2];
    assign rel_diff  = i_in_data.release_address - base_al;
    assign rel_idx   = rel_diff[ADDR_W-1:BLOCK_SIZE_LOG2];

    // scan, mark and free helpers
    assign out_free   = !r_out_valid || !i_out_stall;
    assign scan_issue = r_rd_idx < used;
    assign run_start  = (r_run == '0) ? r_chk_idx : r_first;
    assign run_next   = r_run + CNT_W'(1);
    assign mk_next    = r_mk + CNT_W'(1);
    assign mk_addr    = CNT_W'(r_first) + r_mk;
    assign free_next  = r_idx + CNT_W'(1);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // next state and datapath
    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_len       = r_len;
        n_run       = r_run;
        n_first     = r_first;
        n_rd_idx    = r_rd_idx;
        n_chk_idx   = r_chk_idx;
        n_chk_vld   = r_chk_vld;
        n_idx       = r_idx;
        n_mk        = r_mk;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_waddr   = r_idx[IDX_W-1:0];
        ram_wdata   = ENT_FREE;
        ram_raddr   = r_idx[IDX_W-1:0];

        case (r_state)
            // sweep the table back to free after reset
            S_CLEAR: begin
                ram_we = 1'b1;
                n_idx  = free_next;
                if (r_idx == CNT_W'(NUM_BLOCKS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            // take a request and check the easy failures
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res.granted_address = '0;
                    if (i_in_data.mode == MODE_ALLOC) begin
                        if (req_len == '0 || LEN_CMP_W'(req_len) > LEN_CMP_W'(used)) begin
                            n_res.status = ST_NOSPACE;
                            n_state      = S_RESP;
                        end else begin
                            n_len     = CNT_W'(req_len);
                            n_run     = '0;
                            n_rd_idx  = '0;
                            n_chk_vld = 1'b0;
                            n_state   = S_SCAN;
                        end
                    end else begin
                        if (i_in_data.release_address < base_al ||
                            FIX_CMP_W'(rel_idx) >= FIX_CMP_W'(used)) begin
                            n_res.status = ST_BADADDR;
                            n_state      = S_RESP;
                        end else begin
                            n_idx   = CNT_W'(rel_idx);
                            n_state = S_FREE_RD;
                        end
                    end
                end
            end

            // first-fit scan, one entry a cycle, checked on the registered read data behind the read address
            S_SCAN: begin
                ram_raddr = r_rd_idx[IDX_W-1:0];
                n_rd_idx  = scan_issue ? run_next - r_run + r_rd_idx : r_rd_idx;
                n_chk_vld = scan_issue;
                n_chk_idx = r_rd_idx[IDX_W-1:0];
                if (r_chk_vld) begin
                    if ((ram_rdata & ENT_TAKEN) != ENT_FREE) begin
                        n_run = '0;
                    end else begin
                        n_first = run_start;
                        n_run   = run_next;
                        if (run_next == r_len) begin
                            n_res.granted_address = base_al +
                                ADDR_W'(64'(run_start) << BLOCK_SIZE_LOG2);
                            n_res.status = ST_DONE;
                            n_mk         = '0;
                            n_state      = S_MARK;
                        end
                    end
                end else if (!scan_issue) begin
                    n_res.granted_address = '0;
                    n_res.status          = ST_NOSPACE;
                    n_state               = S_RESP;
                end
            end

            // write the granted run as a chain
            S_MARK: begin
                ram_we    = 1'b1;
                ram_waddr = mk_addr[IDX_W-1:0];
                ram_wdata = ENT_TAKEN;
                if (r_mk == '0) begin
                    ram_wdata = ram_wdata | ENT_FIRST;
                end
                if (mk_next != r_len) begin
                    ram_wdata = ram_wdata | ENT_NEXT;
                end
                n_mk = mk_next;
                if (mk_next == r_len) begin
                    n_state = S_RESP;
                end
            end

            // first read of the free chain
            S_FREE_RD: begin
                n_state = S_FREE_WR;
            end

            // clear one entry and follow has-next
            S_FREE_WR: begin
                ram_we = 1'b1;
                if ((ram_rdata & ENT_NEXT) != ENT_FREE && free_next < used) begin
                    ram_raddr = free_next[IDX_W-1:0];
                    n_idx     = free_next;
                end else begin
                    n_res.granted_address = '0;
                    n_res.status          = ST_DONE;
                    n_state               = S_RESP;
                end
            end

            // hand the result to the output register
            S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_chk_vld   <= 1'b0;
            r_heap_base <= HEAP_BASE_RST;
            r_biu       <= BLOCKS_IN_USE_RST;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            r_chk_vld   <= n_chk_vld;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_HEAP_BASE:     r_heap_base <= i_cfg_wdata;
                    CFG_BLOCKS_IN_USE: r_biu       <= i_cfg_wdata[BIU_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        r_out_data <= n_out_data;
        r_res      <= n_res;
        r_len      <= n_len;
        r_run      <= n_run;
        r_first    <= n_first;
        r_rd_idx   <= n_rd_idx;
        r_chk_idx  <= n_chk_idx;
        r_mk       <= n_mk;
    end

    // clearing pass writes free entries only
    a_clear_writes_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> ram_we && ram_wdata == ENT_FREE)
        else $error("clearing pass wrote a non-free entry");

    // marking never leaves the used part of the table
    a_mark_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MARK |-> mk_addr < used)
        else $error("run marking outside used blocks");

    // a free walk stays inside the used blocks
    a_free_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FREE_WR |-> r_idx < used)
        else $error("free walk outside used blocks");

    // failed results carry a zero address
    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.status != ST_DONE |-> r_out_data.granted_address == '0)
        else $error("failure result with nonzero address");

    // a new result is only loaded when the previous one was taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out_data))
        else $error("stalled result overwritten");

endmodule

@@ rtl/bthalloc_ram.sv @@
// bthalloc_ram.sv: generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module bthalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ dv/block_table_heap_allocator_tb.sv @@
// block_table_heap_allocator_tb.sv: self-checking testbench for the block table heap allocator
`timescale 1ns / 1ps
module block_table_heap_allocator_tb;
    import bthalloc_pkg::*;

    localparam int unsigned BLK_BYTES      = 1 << BLOCK_SIZE_LOG2;
    localparam int          WATCHDOG_LIMIT = 60000;
    localparam int          HOLD_AT        = 125;
    localparam int          HOLD_LEN       = 400;
    localparam int          END_WAIT       = 16;
    localparam logic [ADDR_W-1:0] DBASE    = 32'h0010_0000;

    // dut connections; the dut inputs are driven to known values from time zero
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    t_req              in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_resp             out_data;
    logic              cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [ADDR_W-1:0] cfg_wdata = '0;

    // shadow of the registers and of the block table
    logic [ADDR_W-1:0] cfg_base = HEAP_BASE_RST;
    logic [BIU_W-1:0]  cfg_biu = BLOCKS_IN_USE_RST;
    bit [ENT_W-1:0]    blk_table [NUM_BLOCKS];
    logic [ADDR_W-1:0] granted_runs [$];

    // request backlog and results still owed by the block
    t_req  req_backlog [$];
    t_resp resp_due [$];
    t_resp due;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int n_pushed = 0;
    int n_in = 0;
    int n_out = 0;
    int errors = 0;
    int n_granted = 0;
    int n_nospace = 0;
    int n_badaddr = 0;
    int n_freed = 0;
    int quiet_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    logic in_taken = 1'b0;
    logic out_taken = 1'b0;

    block_table_heap_allocator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // expected answer for one request; updates the shadow table
    function automatic t_resp predict_grant(input t_req rq);
        t_resp             r;
        int unsigned       used;
        int unsigned       run;
        int unsigned       first_blk;
        int unsigned       i;
        int                k;
        longint unsigned   need;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] idx;
        logic [ENT_W-1:0]  e;
        bit                found;
        bit                walking;
        used = (cfg_biu > NUM_BLOCKS) ? NUM_BLOCKS : cfg_biu;
        base = cfg_base & ~BLK_MASK;
        r.granted_address = '0;
        r.status = ST_DONE;
        if (rq.mode == MODE_ALLOC) begin
            need = ({32'd0, rq.request_bytes} + 64'(BLK_MASK)) >> BLOCK_SIZE_LOG2;
            found = 1'b0;
            run = 0;
            first_blk = 0;
            if (need != 0 && need <= used) begin
                // first-fit search for a free run
                for (i = 0; i < used && !found; i++) begin
                    if ((blk_table[i] & ENT_TAKEN) != '0) begin
                        run = 0;
                    end else begin
                        if (run == 0) first_blk = i;
                        run++;
                        if (run == need) found = 1'b1;
                    end
                end
            end
            if (!found) begin
                r.status = ST_NOSPACE;
            end else begin
                // chain the run together
                for (i = 0; i < need; i++) begin
                    e = ENT_TAKEN;
                    if (i == 0) e |= ENT_FIRST;
                    if (i + 1 < need) e |= ENT_NEXT;
                    blk_table[first_blk + i] = e;
                end
                r.granted_address = base + (ADDR_W'(first_blk) << BLOCK_SIZE_LOG2);
                granted_runs.push_back(r.granted_address);
            end
        end else begin
            idx = (rq.release_address - base) >> BLOCK_SIZE_LOG2;
            if (rq.release_address < base || idx >= used) begin
                r.status = ST_BADADDR;
            end else begin
                // walk the has-next chain, never past the used blocks
                walking = 1'b1;
                for (i = idx; i < used && walking; i++) begin
                    e = blk_table[i];
                    blk_table[i] = ENT_FREE;
                    if ((e & ENT_NEXT) == '0) walking = 1'b0;
                end
                // forget runs whose head got cleared
                for (k = granted_runs.size() - 1; k >= 0; k--) begin
                    idx = (granted_runs[k] - base) >> BLOCK_SIZE_LOG2;
                    if (idx >= used || (blk_table[idx] & ENT_FIRST) == '0)
                        granted_runs.delete(k);
                end
            end
        end
        return r;
    endfunction

    // random request, mostly allocations and frees of live runs
    function automatic t_req next_request();
        t_req              rq;
        int unsigned       used;
        int unsigned       pick;
        int unsigned       nblk;
        logic [ADDR_W-1:0] base;
        used = (cfg_biu > NUM_BLOCKS) ? NUM_BLOCKS : cfg_biu;
        base = cfg_base & ~BLK_MASK;
        pick = $urandom_range(99);
        rq.mode = ($urandom_range(99) < 55) ? MODE_ALLOC : MODE_FREE;
        rq.request_bytes = $urandom;
        rq.release_address = $urandom;
        if (rq.mode == MODE_ALLOC) begin
            if (pick < 6) begin
                rq.request_bytes = '0;
            end else if (pick < 14) begin
                rq.request_bytes = $urandom;
            end else if (pick < 20) begin
                rq.request_bytes = used * BLK_BYTES;
            end else begin
                nblk = $urandom_range(1, (used >= 6) ? 6 : ((used == 0) ? 2 : used));
                rq.request_bytes = (nblk - 1) * BLK_BYTES + $urandom_range(1, BLK_BYTES);
            end
        end else begin
            if (pick < 65 && granted_runs.size() != 0) begin
                rq.release_address = granted_runs[$urandom_range(0, granted_runs.size() - 1)];
                if ($urandom_range(3) == 0)
                    rq.release_address += $urandom_range(0, 2 * BLK_BYTES);
            end else if (pick < 85) begin
                rq.release_address = base
                    + ((used == 0) ? 0 : $urandom_range(0, used * BLK_BYTES - 1));
            end else if (pick >= 93) begin
                rq.release_address = base - $urandom_range(1, BLK_BYTES);
            end
        end
        return rq;
    endfunction

    task automatic push_request(input logic md, input logic [ADDR_W-1:0] bytes,
                                input logic [ADDR_W-1:0] addr);
        t_req rq;
        rq.mode = md;
        rq.request_bytes = bytes;
        rq.release_address = addr;
        req_backlog.push_back(rq);
        n_pushed++;
    endtask

    // wait until every request is in and every result is out
    task automatic wait_drained();
        while (n_in != n_pushed || resp_due.size() != 0) @(negedge clk);
    endtask

    // both registers, written while no request is outstanding
    task automatic set_heap(input logic [ADDR_W-1:0] base, input logic [BIU_W-1:0] biu);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_HEAP_BASE;
        cfg_wdata <= base;
        @(negedge clk);
        cfg_addr <= CFG_BLOCKS_IN_USE;
        cfg_wdata <= ADDR_W'(biu);
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_base = base;
        cfg_biu = biu;
        granted_runs.delete();
    endtask

    task automatic run_phase(input int count, input logic [ADDR_W-1:0] base,
                             input logic [BIU_W-1:0] biu);
        t_req rq;
        wait_drained();
        repeat (END_WAIT) @(negedge clk);
        set_heap(base, biu);
        for (int n = 0; n < count; n++) begin
            while (req_backlog.size() >= 2) @(negedge clk);
            rq = next_request();
            push_request(rq.mode, rq.request_bytes, rq.release_address);
        end
    endtask

    // request driver
    always @(negedge clk) begin
        if (!in_valid || in_taken) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                in_data <= req_backlog.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result stall, with one long hold once the run is well under way
    always @(negedge clk) begin
        if (!hold_done && n_in >= HOLD_AT) begin
            hold_left = HOLD_LEN;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // monitor: predict on each request transaction, check each result transaction
    always @(posedge clk) begin
        in_taken = rst_n && in_valid && !in_stall;
        out_taken = rst_n && out_valid && !out_stall;
        if (in_taken) begin
            due = predict_grant(in_data);
            resp_due.push_back(due);
            n_in++;
            if (due.status == ST_NOSPACE) n_nospace++;
            else if (due.status == ST_BADADDR) n_badaddr++;
            else if (in_data.mode == MODE_ALLOC) n_granted++;
            else n_freed++;
        end
        if (out_taken) begin
            if (resp_due.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual addr %h status %0d",
                         $time, out_data.granted_address, out_data.status);
                errors++;
            end else begin
                due = resp_due.pop_front();
                n_out++;
                if (out_data.granted_address !== due.granted_address) begin
                    $display("%0t: granted_address expected %h actual %h",
                             $time, due.granted_address, out_data.granted_address);
                    errors++;
                end
                if (out_data.status !== due.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, due.status, out_data.status);
                    errors++;
                end
            end
        end
        // watchdog on cycles without any transaction
        if (in_taken || out_taken) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, resp_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        snd_idle_pct = 8;
        rcv_idle_pct = 47;

        // directed: small heap, every special case by hand
        set_heap(DBASE, 13'd8);
        push_request(MODE_ALLOC, 32'h0000_0000, 32'hFFFF_FFFF);
        push_request(MODE_ALLOC, 32'h0000_0001, 32'hFFFF_FFFF);
        push_request(MODE_ALLOC, 32'h0000_2001, 32'h0000_0000);
        push_request(MODE_ALLOC, 32'h0000_1000, 32'hFFFF_FFFF);
        push_request(MODE_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000);
        push_request(MODE_ALLOC, 32'h0000_4000, 32'hFFFF_FFFF); // tail run too short
        push_request(MODE_FREE, 32'hFFFF_FFFF, DBASE + 32'h1123); // unaligned head
        push_request(MODE_FREE, 32'h0000_0000, DBASE);
        push_request(MODE_ALLOC, 32'h0000_4000, 32'h0000_0000);
        push_request(MODE_FREE, 32'hFFFF_FFFF, DBASE + 32'h2005); // inside a run
        push_request(MODE_FREE, 32'h0000_0000, DBASE + 32'h6000); // already free
        push_request(MODE_FREE, 32'hFFFF_FFFF, DBASE - 32'h1);    // below base
        push_request(MODE_FREE, 32'h0000_0000, DBASE + 32'h8000); // past used blocks
        push_request(MODE_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_request(MODE_FREE, 32'h0000_0000, 32'h0000_0000);
        push_request(MODE_FREE, 32'hFFFF_FFFF, DBASE);
        push_request(MODE_FREE, 32'h0000_0000, DBASE + 32'h4000);
        push_request(MODE_ALLOC, 32'h0000_8000, 32'hFFFF_FFFF); // whole heap
        push_request(MODE_ALLOC, 32'h0000_0001, 32'h0000_0000); // heap full
        push_request(MODE_FREE, 32'hFFFF_FFFF, DBASE + 32'h7FFF);
        push_request(MODE_FREE, 32'h0000_0000, DBASE);

        // random phases over several heap settings
        run_phase(30, 32'hFFFF_F000, 13'd16);                  // top base, address wrap
        run_phase(14, $urandom & ~BLK_MASK, 13'd1);            // single block
        run_phase(8, 32'h0000_0000, 13'd0);                    // no blocks at all
        snd_idle_pct = 47;
        rcv_idle_pct = 8;
        run_phase(8, $urandom | 32'h1, 13'h1FFF);              // full table, unaligned base
        run_phase(30, $urandom & ~BLK_MASK, BIU_W'($urandom_range(2, 64)));
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_phase(30, $urandom & ~BLK_MASK, 13'd32);

        wait_drained();
        repeat (END_WAIT) @(negedge clk);
        $display("%0d requests checked: %0d granted, %0d freed, %0d no space, %0d bad address",
                 n_out, n_granted, n_freed, n_nospace, n_badaddr);
        $display("heap sizes from none to full table, base at both ends, stalls on both sides");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ block_table_heap_allocator.f @@
rtl/bthalloc_pkg.sv
rtl/bthalloc_ram.sv
rtl/block_table_heap_allocator.sv
dv/block_table_heap_allocator_tb.sv
